// ===== hw/rtl/ams_pkg.sv =====
`default_nettype none

package ams_pkg;

  // Default number of fraction bits of all fixed-point positions.
  localparam int FracBitsDefault = 16;

  // Field widths.
  localparam int PosW      = 32;
  localparam int TolW      = 31;
  localparam int StallW    = 8;
  localparam int EpsW      = 16;
  localparam int RetryW    = 4;
  localparam int StatusW   = 3;
  localparam int ReqW      = 2;

  // Configuration port.
  localparam int AddrW     = 5;
  localparam int DataW     = 32;
  localparam logic [2:0] REG_TARGET      = 3'd0;
  localparam logic [2:0] REG_TOLERANCE   = 3'd1;
  localparam logic [2:0] REG_STALL_LIMIT = 3'd2;
  localparam logic [2:0] REG_STALL_EPS   = 3'd3;
  localparam logic [2:0] REG_RETRY_LIMIT = 3'd4;

  // Reset values of the limits that do not depend on the fixed-point format.
  localparam logic [StallW-1:0] StallLimitReset = 8'd38;
  localparam logic [RetryW-1:0] RetryLimitReset = 4'd4;

  // Request kinds.
  typedef enum logic [ReqW-1:0] {
    REQ_START = 2'd0,
    REQ_POLL  = 2'd1,
    REQ_FINAL = 2'd2,
    REQ_ABORT = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_POLLING    = 3'd0,
    ST_REACHED    = 3'd1,
    ST_REISSUE    = 3'd2,
    ST_TIMEOUT    = 3'd3,
    ST_FINAL_OK   = 3'd4,
    ST_FINAL_FAIL = 3'd5,
    ST_ABORTED    = 3'd6,
    ST_IGNORED    = 3'd7
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/actuator_move_supervisor.sv =====
// A result appears on the master side in the cycle after its request is accepted.
// Throughput: one request per cycle with m_tready high, set by one registered update.
// A new request is taken in the same cycle as the previous result leaves; a result that
// waits for m_tready holds s_tready low.
// Reset (rst, synchronous, active high) clears the move state and counters, sets the
// previous reading to -1.0 and loads the configuration registers with their defaults.
`default_nettype none

module actuator_move_supervisor #(
  parameter int FRAC_BITS = ams_pkg::FracBitsDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Request stream.
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [39:0]                s_tdata,   // moving, reading[32:1], zero pad
  input  wire logic [2:0]                 s_tuser,   // req_type[1:0], reading_valid[2]
  // Result stream.
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [47:0]                     m_tdata,   // position_out, stall_count_out,
                                                     // retry_count_out, zero pad
  output logic [2:0]                      m_tuser,   // status
  // Configuration port.
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ams_pkg::AddrW-1:0]  paddr,
  input  wire logic [ams_pkg::DataW-1:0]  pwdata,
  output logic [ams_pkg::DataW-1:0]       prdata,
  output logic                            pready
);

  localparam int PosW   = ams_pkg::PosW;
  localparam int TolW   = ams_pkg::TolW;
  localparam int StallW = ams_pkg::StallW;
  localparam int EpsW   = ams_pkg::EpsW;
  localparam int RetryW = ams_pkg::RetryW;

  // Reset values that follow from the fixed-point format.
  localparam longint OneFix = longint'(1) << FRAC_BITS;
  localparam logic [TolW-1:0] TolReset = TolW'((OneFix * 5 + 50) / 100);
  localparam logic [EpsW-1:0] EpsReset = EpsW'((OneFix + 500) / 1000);
  localparam logic [PosW-1:0] LastReadingReset = PosW'(-OneFix);

  localparam logic [StallW-1:0] StallMax = {StallW{1'b1}};
  localparam logic [RetryW-1:0] RetryMax = {RetryW{1'b1}};

  // Configuration registers.
  logic signed [PosW-1:0] target_position;
  logic [TolW-1:0]        tolerance;
  logic [StallW-1:0]      stall_limit;
  logic [EpsW-1:0]        stall_epsilon;
  logic [RetryW-1:0]      retry_limit;

  // Move state.
  logic                   running, running_next;
  logic                   awaiting_final, awaiting_final_next;
  logic [StallW-1:0]      stall_tally, stall_tally_next;
  logic [RetryW-1:0]      retry_count, retry_count_next;
  logic signed [PosW-1:0] last_reading, last_reading_next;
  logic                   last_valid, last_valid_next;
  logic signed [PosW-1:0] stored_position, stored_position_next;

  // Result register.
  ams_pkg::status_t       out_status;
  ams_pkg::status_t       status_next;

  // Unpacked request fields.
  ams_pkg::req_t          req_type;
  logic                   moving;
  logic signed [PosW-1:0] reading;
  logic                   reading_valid;

  logic                   cfg_write;
  logic [2:0]             cfg_idx;
  logic                   in_accept;

  // Distance arithmetic, exact in 34 bits.
  logic signed [33:0]     step_diff;
  logic signed [33:0]     final_diff;
  logic signed [33:0]     eps_ext;
  logic signed [33:0]     tol_ext;
  logic signed [33:0]     reading_ext;
  logic signed [33:0]     win_low;
  logic signed [33:0]     win_high;
  logic                   stall;
  logic                   in_window;
  logic                   final_ok;
  logic [StallW-1:0]      stall_inc;
  logic [RetryW-1:0]      retry_inc;

  assign req_type      = ams_pkg::req_t'(s_tuser[1:0]);
  assign reading_valid = s_tuser[2];
  assign moving        = s_tdata[0];
  assign reading       = s_tdata[PosW:1];

  assign in_accept = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;

  // Configuration write and read-back.
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      tolerance       <= TolReset;
      stall_limit     <= ams_pkg::StallLimitReset;
      stall_epsilon   <= EpsReset;
      retry_limit     <= ams_pkg::RetryLimitReset;
    end else if (cfg_write) begin
      case (cfg_idx)
        ams_pkg::REG_TARGET:      target_position <= pwdata[PosW-1:0];
        ams_pkg::REG_TOLERANCE:   tolerance       <= pwdata[TolW-1:0];
        ams_pkg::REG_STALL_LIMIT: stall_limit     <= pwdata[StallW-1:0];
        ams_pkg::REG_STALL_EPS:   stall_epsilon   <= pwdata[EpsW-1:0];
        ams_pkg::REG_RETRY_LIMIT: retry_limit     <= pwdata[RetryW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ams_pkg::REG_TARGET:      prdata = target_position;
      ams_pkg::REG_TOLERANCE:   prdata = {1'b0, tolerance};
      ams_pkg::REG_STALL_LIMIT: prdata = {24'd0, stall_limit};
      ams_pkg::REG_STALL_EPS:   prdata = {16'd0, stall_epsilon};
      ams_pkg::REG_RETRY_LIMIT: prdata = {28'd0, retry_limit};
      default:                  prdata = '0;
    endcase
  end

  // Comparisons against the previous reading and the target window.
  assign reading_ext = 34'(reading);
  assign eps_ext     = {18'd0, stall_epsilon};
  assign tol_ext     = {3'd0, tolerance};
  assign step_diff   = reading_ext - 34'(last_reading);
  assign final_diff  = reading_ext - 34'(target_position);
  assign win_low     = 34'(target_position) - tol_ext;
  assign win_high    = 34'(target_position) + tol_ext;

  assign stall     = !last_valid || !reading_valid ||
                     ((step_diff < eps_ext) && (step_diff > -eps_ext));
  assign in_window = reading_valid && (reading_ext >= win_low) && (reading_ext <= win_high);
  assign final_ok  = reading_valid && (final_diff < tol_ext) && (final_diff > -tol_ext);

  assign stall_inc = (stall_tally == StallMax) ? stall_tally : stall_tally + 1'b1;
  assign retry_inc = (retry_count == RetryMax) ? retry_count : retry_count + 1'b1;

  // Next state and status for the request at the slave side.
  always_comb begin
    running_next         = running;
    awaiting_final_next  = awaiting_final;
    stall_tally_next     = stall_tally;
    retry_count_next     = retry_count;
    last_reading_next    = last_reading;
    last_valid_next      = last_valid;
    stored_position_next = stored_position;
    status_next          = ams_pkg::ST_IGNORED;

    case (req_type)
      ams_pkg::REQ_START: begin
        running_next        = 1'b1;
        awaiting_final_next = 1'b0;
        stall_tally_next    = '0;
        retry_count_next    = '0;
        last_reading_next   = LastReadingReset;
        last_valid_next     = 1'b1;
        status_next         = ams_pkg::ST_POLLING;
      end
      ams_pkg::REQ_POLL: begin
        if (running) begin
          if (reading_valid) begin
            stored_position_next = reading;
          end
          if (moving) begin
            status_next = ams_pkg::ST_POLLING;
            if (stall) begin
              stall_tally_next = stall_inc;
              if (stall_inc > stall_limit) begin
                running_next = 1'b0;
                status_next  = ams_pkg::ST_TIMEOUT;
              end
            end else begin
              stall_tally_next = '0;
            end
            last_reading_next = reading;
            last_valid_next   = reading_valid;
          end else if (in_window) begin
            running_next        = 1'b0;
            awaiting_final_next = 1'b1;
            status_next         = ams_pkg::ST_REACHED;
          end else if (retry_inc > retry_limit) begin
            retry_count_next = '0;
            status_next      = ams_pkg::ST_REISSUE;
          end else begin
            retry_count_next = retry_inc;
            status_next      = ams_pkg::ST_POLLING;
          end
        end
      end
      ams_pkg::REQ_FINAL: begin
        if (awaiting_final) begin
          awaiting_final_next = 1'b0;
          if (reading_valid) begin
            stored_position_next = reading;
          end
          status_next = final_ok ? ams_pkg::ST_FINAL_OK : ams_pkg::ST_FINAL_FAIL;
        end
      end
      ams_pkg::REQ_ABORT: begin
        if (running || awaiting_final) begin
          running_next        = 1'b0;
          awaiting_final_next = 1'b0;
          status_next         = ams_pkg::ST_ABORTED;
        end
      end
      default: begin
      end
    endcase
  end

  // State update and result register, loaded with every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      awaiting_final  <= 1'b0;
      stall_tally     <= '0;
      retry_count     <= '0;
      last_reading    <= LastReadingReset;
      last_valid      <= 1'b1;
      stored_position <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (in_accept) begin
        running         <= running_next;
        awaiting_final  <= awaiting_final_next;
        stall_tally     <= stall_tally_next;
        retry_count     <= retry_count_next;
        last_reading    <= last_reading_next;
        last_valid      <= last_valid_next;
        stored_position <= stored_position_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_status <= status_next;
    end
  end

  // The counters and position on the result side are the state after the request.
  assign m_tdata = {4'd0, retry_count, stall_tally, stored_position};
  assign m_tuser = out_status;

  // A move is never both running and waiting for its final check.
  assert property (@(posedge clk) disable iff (rst) !(running && awaiting_final))
    else $error("running and awaiting_final set together");

  // A start request leaves a fresh, running move.
  assert property (@(posedge clk) disable iff (rst)
    in_accept && req_type == ams_pkg::REQ_START |=>
      running && stall_tally == '0 && retry_count == '0 && last_valid)
    else $error("start did not rearm the move");

  // A stall timeout always ends the move.
  assert property (@(posedge clk) disable iff (rst)
    in_accept && status_next == ams_pkg::ST_TIMEOUT |=> !running && m_tvalid)
    else $error("timeout left the move running");

  // A reissue is reported with a cleared retry count.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status == ams_pkg::ST_REISSUE |-> retry_count == '0)
    else $error("reissue with nonzero retry count");

endmodule

`default_nettype wire
